[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Word types and character codes for the text console.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  localparam int CURSOR_W = 11;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'd10;

  typedef struct packed {
    logic               operation;
    logic [7:0]         char_code;
    logic [INDEX_W-1:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/text_console_cursor_scroll.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell console: screen store in one memory, cursor, scroll by
// rotating the top-row base and clearing one row.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  in      | input     | in_word_t  (operation, char_code, cell_index)
//  out     | output    | out_word_t (cursor_position, cell_value, scrolled)
//  cfg     | input     | text_color byte, always ready
//
//  Put: result staged in S_PUSH, after S_SCROLL clears a row when it scrolls.
//  Read: S_READ takes the screen memory's registered read, then S_PUSH.
//  One item in work at a time; the next is taken while the result waits in
//  the output register.
//  After reset the memory is cleared in S_CLEAR, with in_ready low.
//  A stalled output holds its word and blocks only the next result push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tcc_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tcc_pkg::out_word_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  import tcc_pkg::*;

  `include "assert_macros.svh"

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW:0]   CELLS_X    = (AW+1)'(CELLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_PUSH   = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CELLS_X) s = s - CELLS_X;
    return s[AW-1:0];
  endfunction

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;

  state_t            state;
  logic [7:0]        text_color;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     base;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     clr_cnt;
  logic              rd_range;
  logic [CURSOR_W-1:0] res_pos;
  logic [CELL_W-1:0] res_value;
  logic              res_scrolled;

  logic [RW-1:0]     row_next;
  logic [CW-1:0]     col_next;
  logic [AW-1:0]     pos_next;
  logic [AW-1:0]     base_next;
  logic              scroll_now;
  logic [AW-1:0]     wr_lin;
  logic [7:0]        wr_char;
  logic              in_fire;
  logic              in_range;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_range  = (32'(in_data.cell_index) < 32'(CELLS));
  assign rd_addr   = wrap_add(AW'(in_data.cell_index), base);
  assign base_next = (base == LAST_START) ? '0 : base + ROW_STEP;

  always_comb begin
    row_next   = row;
    col_next   = col;
    pos_next   = pos;
    scroll_now = 1'b0;
    wr_char    = in_data.char_code;
    if (in_data.char_code == CH_NEWLINE) begin
      col_next = '0;
      if (row == LAST_ROW) begin
        scroll_now = 1'b1;
        pos_next   = LAST_START;
      end else begin
        row_next = row + 1'b1;
        pos_next = pos - AW'(col) + ROW_STEP;
      end
    end else if (in_data.char_code == CH_BACKSPACE) begin
      wr_char = CH_SPACE;
      if (col != '0) begin
        col_next = col - 1'b1;
        pos_next = pos - 1'b1;
      end else if (row != '0) begin
        row_next = row - 1'b1;
        col_next = LAST_COL;
        pos_next = pos - 1'b1;
      end
    end else if (col == LAST_COL) begin
      col_next = '0;
      if (row == LAST_ROW) begin
        scroll_now = 1'b1;
        pos_next   = LAST_START;
      end else begin
        row_next = row + 1'b1;
        pos_next = pos + 1'b1;
      end
    end else begin
      col_next = col + 1'b1;
      pos_next = pos + 1'b1;
    end
    wr_lin = (in_data.char_code == CH_BACKSPACE) ? pos_next : pos;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = {text_color, CH_SPACE};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_COLOR, CH_SPACE};
      end
      S_SCROLL: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_we    = in_fire && (in_data.operation == OP_PUT) &&
                    (in_data.char_code != CH_NEWLINE);
        mem_waddr = wrap_add(wr_lin, base);
        mem_wdata = {text_color, wr_char};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      text_color <= RESET_COLOR;
      row        <= '0;
      col        <= '0;
      pos        <= '0;
      base       <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) text_color <= cfg_data;
      if (out_valid && out_ready && state != S_PUSH) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_CELL) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.operation == OP_READ) begin
              rd_range     <= in_range;
              res_pos      <= CURSOR_W'(pos);
              res_scrolled <= 1'b0;
              state        <= S_READ;
            end else begin
              row          <= row_next;
              col          <= col_next;
              pos          <= pos_next;
              res_pos      <= CURSOR_W'(pos_next);
              res_value    <= '0;
              res_scrolled <= scroll_now;
              if (scroll_now) begin
                clr_addr <= base;
                clr_cnt  <= '0;
                base     <= base_next;
                state    <= S_SCROLL;
              end else begin
                state <= S_PUSH;
              end
            end
          end
        end
        S_READ: begin
          res_value <= rd_range ? rd_data : '0;
          state     <= S_PUSH;
        end
        S_SCROLL: begin
          clr_addr <= clr_addr + 1'b1;
          clr_cnt  <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_COL) state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            out_data.cursor_position <= res_pos;
            out_data.cell_value      <= res_value;
            out_data.scrolled        <= res_scrolled;
            out_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_AT(a_cursor_sync, clk, rst, 32'(pos) == 32'(row) * COLUMNS + 32'(col), "cursor fields disagree")
  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "second word taken during work")
  `ASSERT_AT(a_scroll_row, clk, rst, state != S_SCROLL || (row == LAST_ROW && pos == LAST_START), "scroll off last row")

endmodule

`default_nettype wire

[test/text_console_cursor_scroll_test.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_test
// Self-checking bench for the text console. A short table of directed words
// covers reset contents, reads out of range, backspace at home and across a
// row, and ignored fields. Random phases follow, each under a fresh text
// color, biased toward newlines, plain text, backspaces or reads. Every result
// word is checked against the table (directed) or an in-bench model of the
// screen, cursor and scroll, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_scroll_test;
  import tcc_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int LIMIT   = 400000;
  localparam int PLAN_N  = 23;
  localparam int PHASES  = 6;

  typedef struct packed {
    in_word_t  w;
    logic      pin;
    out_word_t want;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  logic        pinned = 1'b0;
  out_word_t   pinned_word = '0;
  bit          calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int unsigned stall_left = 0;

  logic [15:0] screen [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  shade;
  out_word_t   result_q [$];

  plan_row_t   plan [PLAN_N];
  int unsigned mix_nl [PHASES] = '{40, 2, 10, 15, 5, 20};
  int unsigned mix_bs [PHASES] = '{5, 5, 30, 10, 5, 10};
  int unsigned mix_rd [PHASES] = '{20, 20, 20, 25, 50, 20};
  int unsigned mix_n  [PHASES] = '{90, 100, 90, 90, 90, 90};

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Step to the next row, scrolling the screen when already on the last one.
  function automatic logic advance_row();
    if (cur_row == ROWS - 1) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {shade, CH_SPACE};
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic out_word_t console_apply(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.operation == OP_READ) begin
      if (w.cell_index < CELLS) r.cell_value = screen[w.cell_index];
    end else if (w.char_code == CH_NEWLINE) begin
      cur_col = 0;
      r.scrolled = advance_row();
    end else if (w.char_code == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = COLUMNS - 1;
      end
      screen[cur_row * COLUMNS + cur_col] = {shade, CH_SPACE};
    end else begin
      screen[cur_row * COLUMNS + cur_col] = {shade, w.char_code};
      if (cur_col == COLUMNS - 1) begin
        cur_col = 0;
        r.scrolled = advance_row();
      end else begin
        cur_col++;
      end
    end
    r.cursor_position = CURSOR_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic op, logic [7:0] ch, logic [10:0] idx,
                                         logic [10:0] pos, logic [15:0] val, logic scr);
    plan_row_t p;
    p.w.operation = op;
    p.w.char_code = ch;
    p.w.cell_index = idx;
    p.pin = 1'b1;
    p.want.cursor_position = pos;
    p.want.cell_value = val;
    p.want.scrolled = scr;
    return p;
  endfunction

  function automatic in_word_t random_word(int unsigned nl_pct, int unsigned bs_pct,
                                           int unsigned rd_pct);
    in_word_t    w;
    int unsigned r;
    w.operation = OP_PUT;
    w.char_code = 8'($urandom_range(255));
    w.cell_index = 11'($urandom_range(2047));
    r = $urandom_range(99);
    if (r < rd_pct) begin
      w.operation = OP_READ;
      if ($urandom_range(9) != 0) w.cell_index = 11'($urandom_range(CELLS - 1));
    end else if (r < rd_pct + nl_pct) begin
      w.char_code = CH_NEWLINE;
    end else if (r < rd_pct + nl_pct + bs_pct) begin
      w.char_code = CH_BACKSPACE;
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_word(in_word_t w, logic pin, out_word_t pw);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data     <= w;
    pinned      <= pin;
    pinned_word <= pw;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_color(logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (COLUMNS + 8) @(negedge clk);
  endtask

  // Receiver: random stalls, with calm stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      cycles++;
      if (!rst) begin
        if (cfg_valid && cfg_ready) shade = cfg_data;
        if (in_valid && in_ready) begin
          pinned_word_check: begin
            out_word_t got;
            got = console_apply(in_data);
            result_q.push_back(pinned ? pinned_word : got);
          end
        end
        if (out_valid && out_ready) begin
          if (result_q.size() == 0) begin
            $error("result word with nothing expected: %h", out_data);
            errors++;
          end else begin
            compare: begin
              out_word_t w;
              w = result_q.pop_front();
              if (out_data.cursor_position !== w.cursor_position) begin
                $error("cursor_position: expected %0d, got %0d",
                       w.cursor_position, out_data.cursor_position);
                errors++;
              end
              if (out_data.cell_value !== w.cell_value) begin
                $error("cell_value: expected %h, got %h", w.cell_value, out_data.cell_value);
                errors++;
              end
              if (out_data.scrolled !== w.scrolled) begin
                $error("scrolled: expected %b, got %b", w.scrolled, out_data.scrolled);
                errors++;
              end
            end
          end
        end
      end
    end
  end

  initial begin
    foreach (screen[i]) screen[i] = {RESET_COLOR, CH_SPACE};
    cur_row = 0;
    cur_col = 0;
    shade   = RESET_COLOR;

    plan[0]  = plan_row(OP_READ, 8'h00, 11'd0,    11'd0,   16'h0A20, 1'b0);
    plan[1]  = plan_row(OP_READ, 8'hFF, 11'd1999, 11'd0,   16'h0A20, 1'b0);
    plan[2]  = plan_row(OP_READ, 8'h00, 11'd2000, 11'd0,   16'h0000, 1'b0);
    plan[3]  = plan_row(OP_READ, 8'hFF, 11'd2047, 11'd0,   16'h0000, 1'b0);
    plan[4]  = plan_row(OP_PUT,  CH_BACKSPACE, 11'd0, 11'd0, 16'h0000, 1'b0);
    plan[5]  = plan_row(OP_READ, 8'h00, 11'd0,    11'd0,   16'h0A20, 1'b0);
    plan[6]  = plan_row(OP_PUT,  8'h41, 11'd2047, 11'd1,   16'h0000, 1'b0);
    plan[7]  = plan_row(OP_READ, CH_BACKSPACE, 11'd0, 11'd1, 16'h0A41, 1'b0);
    plan[8]  = plan_row(OP_PUT,  8'hFF, 11'd0,    11'd2,   16'h0000, 1'b0);
    plan[9]  = plan_row(OP_PUT,  8'h00, 11'd1024, 11'd3,   16'h0000, 1'b0);
    plan[10] = plan_row(OP_READ, 8'h00, 11'd1,    11'd3,   16'h0AFF, 1'b0);
    plan[11] = plan_row(OP_READ, 8'h00, 11'd2,    11'd3,   16'h0A00, 1'b0);
    plan[12] = plan_row(OP_PUT,  CH_BACKSPACE, 11'd0, 11'd2, 16'h0000, 1'b0);
    plan[13] = plan_row(OP_READ, 8'h00, 11'd2,    11'd2,   16'h0A20, 1'b0);
    plan[14] = plan_row(OP_PUT,  CH_NEWLINE, 11'd0, 11'd80, 16'h0000, 1'b0);
    plan[15] = plan_row(OP_PUT,  CH_BACKSPACE, 11'd0, 11'd79, 16'h0000, 1'b0);
    plan[16] = plan_row(OP_READ, 8'h00, 11'd79,   11'd79,  16'h0A20, 1'b0);
    plan[17] = plan_row(OP_PUT,  CH_BACKSPACE, 11'd0, 11'd78, 16'h0000, 1'b0);
    plan[18] = plan_row(OP_PUT,  CH_NEWLINE, 11'd0, 11'd80, 16'h0000, 1'b0);
    plan[19] = plan_row(OP_PUT,  CH_NEWLINE, 11'd2047, 11'd160, 16'h0000, 1'b0);
    plan[20] = plan_row(OP_PUT,  8'h09, 11'd0,    11'd161, 16'h0000, 1'b0);
    plan[21] = plan_row(OP_READ, 8'h00, 11'd160,  11'd161, 16'h0A09, 1'b0);
    plan[22] = plan_row(OP_READ, 8'h00, 11'd0,    11'd161, 16'h0A41, 1'b0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Hold off until the screen clear after reset is done.
    do @(posedge clk); while (!in_ready);
    @(negedge clk);

    foreach (plan[k]) send_word(plan[k].w, plan[k].pin, plan[k].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_color(p == 0 ? 8'hFF : p == 1 ? 8'h00 : 8'($urandom_range(255)));
      calm = (p == 3);
      repeat (mix_n[p]) send_word(random_word(mix_nl[p], mix_bs[p], mix_rd[p]), 1'b0, '0);
    end
    calm = 1'b0;
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
